// File: design/thst_pkg.sv
// Shared types, codes and constants for the token hash slot tracker.
// No dependencies; imported by token_hash_slot_tracker.
package thst_pkg;

  // Default number of table slots, and the largest modulus ever used.
  localparam int TableDepthDefault = 256;
  localparam int SlotLimit         = 256;

  // Shortest word that is hashed.
  localparam int MinWord = 3;

  // Widest dividend reaching the remainder unit: remainder * 10 + 9 < 4096.
  localparam int DivSteps = 12;

  localparam int CfgW = 9;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_LETTER = 2'd1,
    CLS_DIGIT  = 2'd2
  } class_e;

  typedef enum logic [1:0] {
    KIND_WORD    = 2'd0,
    KIND_INTEGER = 2'd1,
    KIND_MIX_ERR = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] slot_index;
    kind_e      token_kind;
    logic       slot_was_occupied;
  } out_item_t;

  function automatic class_e classify(input logic [7:0] b);
    class_e c;
    c = CLS_NONE;
    if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) begin
      c = CLS_LETTER;
    end else if (b >= 8'h30 && b <= 8'h39) begin
      c = CLS_DIGIT;
    end
    return c;
  endfunction

endpackage

// File: design/token_hash_slot_tracker.sv
// Token hash slot tracker: tokeniser, running modulo hash and slot occupancy.
// Depends on thst_pkg for payload structs, class and kind codes.
//
// Usage
//   Input channel in_valid_i / in_stall_o / in_data_i carries one text byte per
//   transaction, with an end-of-file flag. Output channel out_valid_o /
//   out_stall_i / out_data_o carries at most one result per input byte: the
//   slot a finished token hashes to, its kind, and whether the slot was taken.
//   cfg_we_i / cfg_wdata_i write the table size (modulus); write it only while
//   the block is idle. Zero acts as one, values above the slot count as the
//   slot count.
// Timing
//   A letter or digit runs the shared restoring remainder unit, one dividend bit
//   per cycle, and holds the block until it is done. A delimiter closing a hashed
//   token runs the same unit, then the emit state loads the output register once
//   it is free. A letter-digit mix goes straight to the emit state. Other bytes,
//   and every byte after a letter-digit error, leave the sequencer idle.
//   in_stall_o is high whenever the sequencer is busy.
// Reset and back-pressure
//   Reset clears the token, the halt flag and every occupancy bit, and sets
//   the table size to 256. A result that waits on out_stall_i holds the output
//   register; the block keeps taking bytes until a second result is ready,
//   which then waits in the sequencer. A letter-digit mix emits an error
//   result and halts the block (bytes are taken and dropped) until reset.
module token_hash_slot_tracker
  import thst_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_data_o
);

  localparam int SlotCnt = (TABLE_DEPTH < SlotLimit) ? TABLE_DEPTH : SlotLimit;
  localparam int IdxW    = (SlotCnt > 1) ? $clog2(SlotCnt) : 1;
  localparam int CntW    = $clog2(DivSteps);
  localparam logic [CfgW-1:0] ModCap = CfgW'(SlotCnt);
  localparam logic [CntW-1:0] LastStep = CntW'(DivSteps - 1);
  localparam logic [1:0] MinWordCnt = 2'(MinWord);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [CfgW-1:0]     table_size_q;
  logic [CfgW-1:0]     mod_q, mod_d, mod_now;
  class_e              prev_class_q, prev_class_d;
  logic [1:0]          letter_cnt_q, letter_cnt_d;
  logic [7:0]          rr_q, rr_d;
  logic                halted_q, halted_d;
  logic                hash_op_q, hash_op_d;   // remainder feeds a result, not the token
  logic                eof_q, eof_d;
  logic                err_q, err_d;
  kind_e               kind_q, kind_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DivSteps-1:0] dvd_q, dvd_d;
  logic [CfgW-1:0]     rem_q, rem_d;
  logic [7:0]          slot_q, slot_d;
  logic [SlotCnt-1:0]  occ_q, occ_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_data_q, out_data_d;

  logic                in_fire;
  class_e              cls;
  logic [CfgW:0]       shifted;
  logic [CfgW:0]       diff;
  logic                out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cls        = classify(in_data_i.char_byte);

  always_comb begin
    mod_now = table_size_q;
    if (table_size_q == '0) begin
      mod_now = CfgW'(1);
    end else if (table_size_q > ModCap) begin
      mod_now = ModCap;
    end
  end

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  assign shifted = {rem_q, dvd_q[DivSteps-1]};
  assign diff    = shifted - {1'b0, mod_q};

  always_comb begin
    state_d      = state_q;
    mod_d        = mod_q;
    prev_class_d = prev_class_q;
    letter_cnt_d = letter_cnt_q;
    rr_d         = rr_q;
    halted_d     = halted_q;
    hash_op_d    = hash_op_q;
    eof_d        = eof_q;
    err_d        = err_q;
    kind_d       = kind_q;
    cnt_d        = cnt_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    slot_d       = slot_q;
    occ_d        = occ_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && !halted_q) begin
          mod_d = mod_now;
          eof_d = in_data_i.end_of_file;
          cnt_d = '0;
          rem_d = '0;
          if (cls != CLS_NONE && prev_class_q != CLS_NONE && prev_class_q != cls) begin
            halted_d     = 1'b1;
            err_d        = 1'b1;
            prev_class_d = CLS_NONE;
            letter_cnt_d = '0;
            rr_d         = '0;
            state_d      = ST_EMIT;
          end else if (cls == CLS_LETTER) begin
            dvd_d     = DivSteps'({1'b0, rr_q} + {1'b0, in_data_i.char_byte});
            hash_op_d = 1'b0;
            if (letter_cnt_q != MinWordCnt) begin
              letter_cnt_d = letter_cnt_q + 2'd1;
            end
            prev_class_d = CLS_LETTER;
            if (in_data_i.end_of_file) begin
              prev_class_d = CLS_NONE;
              letter_cnt_d = '0;
            end
            state_d = ST_DIV;
          end else if (cls == CLS_DIGIT) begin
            // remainder * 10 as two shifts, plus the digit value
            dvd_d = DivSteps'({rr_q, 3'b000}) + DivSteps'({rr_q, 1'b0})
                  + DivSteps'(in_data_i.char_byte[3:0]);
            hash_op_d    = 1'b0;
            prev_class_d = in_data_i.end_of_file ? CLS_NONE : CLS_DIGIT;
            letter_cnt_d = '0;
            state_d      = ST_DIV;
          end else begin
            if (prev_class_q == CLS_DIGIT ||
                (prev_class_q == CLS_LETTER && letter_cnt_q == MinWordCnt)) begin
              dvd_d     = DivSteps'(rr_q);
              hash_op_d = 1'b1;
              err_d     = 1'b0;
              kind_d    = (prev_class_q == CLS_DIGIT) ? KIND_INTEGER : KIND_WORD;
              state_d   = ST_DIV;
            end
            prev_class_d = CLS_NONE;
            letter_cnt_d = '0;
            rr_d         = '0;
          end
        end
      end
      ST_DIV: begin
        rem_d = diff[CfgW] ? shifted[CfgW-1:0] : diff[CfgW-1:0];
        dvd_d = {dvd_q[DivSteps-2:0], 1'b0};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == LastStep) begin
          if (hash_op_q) begin
            slot_d  = rem_d[7:0];
            state_d = ST_EMIT;
          end else begin
            rr_d    = eof_q ? 8'd0 : rem_d[7:0];
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        // wait for the output register to drain
        if (out_free) begin
          out_valid_d = 1'b1;
          if (err_q) begin
            out_data_d.slot_index        = '0;
            out_data_d.token_kind        = KIND_MIX_ERR;
            out_data_d.slot_was_occupied = 1'b0;
          end else begin
            out_data_d.slot_index        = slot_q;
            out_data_d.token_kind        = kind_q;
            out_data_d.slot_was_occupied = occ_q[slot_q[IdxW-1:0]];
            occ_d[slot_q[IdxW-1:0]]      = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      table_size_q <= CfgW'(SlotLimit);
      prev_class_q <= CLS_NONE;
      letter_cnt_q <= '0;
      rr_q         <= '0;
      halted_q     <= 1'b0;
      hash_op_q    <= 1'b0;
      eof_q        <= 1'b0;
      err_q        <= 1'b0;
      cnt_q        <= '0;
      occ_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        table_size_q <= cfg_wdata_i;
      end
      prev_class_q <= prev_class_d;
      letter_cnt_q <= letter_cnt_d;
      rr_q         <= rr_d;
      halted_q     <= halted_d;
      hash_op_q    <= hash_op_d;
      eof_q        <= eof_d;
      err_q        <= err_d;
      cnt_q        <= cnt_d;
      occ_q        <= occ_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mod_q      <= mod_d;
    kind_q     <= kind_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    slot_q     <= slot_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A new result is only ever loaded from the emit state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result loaded outside emit state");

  // Only reset releases the halt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt released without reset");

  // An error result implies the block is halted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.token_kind == KIND_MIX_ERR) |-> halted_q)
    else $error("error result while not halted");

  // The partial remainder stays below the modulus throughout a reduction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q != '0) |-> (rem_q < mod_q))
    else $error("partial remainder out of range");

  // A hashed slot always lies inside the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !err_q) |-> ({1'b0, slot_q} < ModCap))
    else $error("slot beyond table");

endmodule
